FILE: rtl/plsu_pkg.sv
// Package for the lookahead steering unit: sequencer states, shared
// divide/square-root unit request types, codes, saturating helpers and absv.
// Used by plsu_divsqrt and path_follow_lookahead_steer_unit.
`default_nettype none

package plsu_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic REG_SPEED     = 1'b0;
  localparam logic REG_LOOKAHEAD = 1'b1;

  localparam logic [23:0] SPEED_RST     = 24'd65536;
  localparam logic [23:0] LOOKAHEAD_RST = 24'd32768;

  localparam logic [30:0] ONE30    = 31'h4000_0000;
  localparam logic [63:0] SQRT_TOP = 64'h4000_0000_0000_0000;

  localparam logic [6:0] SQRT_STEPS = 7'd32;
  localparam logic [6:0] FRAC_STEPS = 7'd30;
  localparam logic [6:0] QUOT_STEPS = 7'd64;

  typedef struct packed {
    logic       start;
    logic       sqrt;
    logic [6:0] steps;
  } dsu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } dsu_rsp_t;

  typedef enum logic [38:0] {
    S_IDLE    = 39'd1 << 0,
    S_E_RD    = 39'd1 << 1,
    S_E_DAT   = 39'd1 << 2,
    S_E_CMP   = 39'd1 << 3,
    S_W1_CHK  = 39'd1 << 4,
    S_W1_RD   = 39'd1 << 5,
    S_W1_SL   = 39'd1 << 6,
    S_W1_MF   = 39'd1 << 7,
    S_W1_EXD  = 39'd1 << 8,
    S_W1_NS   = 39'd1 << 9,
    S_N_NUM1  = 39'd1 << 10,
    S_N_NUM2  = 39'd1 << 11,
    S_N_DEC   = 39'd1 << 12,
    S_N_MF    = 39'd1 << 13,
    S_N_MFD   = 39'd1 << 14,
    S_W1_D2   = 39'd1 << 15,
    S_W1_UPD  = 39'd1 << 16,
    S_W2_CHK  = 39'd1 << 17,
    S_W2_RD   = 39'd1 << 18,
    S_W2_SL   = 39'd1 << 19,
    S_W2_MF   = 39'd1 << 20,
    S_W2_END  = 39'd1 << 21,
    S_V_DIR   = 39'd1 << 22,
    S_V_LEN   = 39'd1 << 23,
    S_VX_MUL  = 39'd1 << 24,
    S_VX_GO   = 39'd1 << 25,
    S_VX_WAIT = 39'd1 << 26,
    S_VY_MUL  = 39'd1 << 27,
    S_VY_GO   = 39'd1 << 28,
    S_VY_WAIT = 39'd1 << 29,
    S_SQX     = 39'd1 << 30,
    S_SQY     = 39'd1 << 31,
    S_RT_GO   = 39'd1 << 32,
    S_RT_WAIT = 39'd1 << 33,
    S_FR_GO   = 39'd1 << 34,
    S_FR_WAIT = 39'd1 << 35,
    S_MF_X    = 39'd1 << 36,
    S_MF_Y    = 39'd1 << 37,
    S_SPARE   = 39'd1 << 38
  } state_t;

  function automatic logic signed [31:0] sdiff(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    if (d > 33'sd1073741823) return 32'sd1073741823;
    else if (d < -33'sd1073741823) return -32'sd1073741823;
    else return d[31:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    else if (v < -64'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] absv(input logic signed [31:0] v);
    return v[31] ? -v : v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/plsu_divsqrt.sv
// Shared iterative unit: restoring division or bit-pair square root, one
// step per cycle. Depends on plsu_pkg for its request and response types.
`default_nettype none

module plsu_divsqrt (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire plsu_pkg::dsu_req_t req,
  input  wire logic [63:0]       a_in,
  input  wire logic [63:0]       n_in,
  input  wire logic [63:0]       d_in,
  output plsu_pkg::dsu_rsp_t     rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        sqrt_r, sqrt_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [63:0] z_r, z_nxt;
  logic [63:0] d_r, d_nxt;
  logic [63:0] sum;
  logic [63:0] tsh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    d_nxt    = d_r;
    sum      = y_r + z_r;
    tsh      = {x_r[62:0], z_r[63]};
    if (req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.sqrt;
      cnt_nxt  = req.steps;
      x_nxt    = a_in;
      y_nxt    = '0;
      z_nxt    = req.sqrt ? plsu_pkg::SQRT_TOP : n_in;
      d_nxt    = d_in;
    end else if (busy_r) begin
      if (sqrt_r) begin
        if (x_r >= sum) begin
          x_nxt = x_r - sum;
          y_nxt = (y_r >> 1) + z_r;
        end else begin
          y_nxt = y_r >> 1;
        end
        z_nxt = z_r >> 2;
      end else begin
        if (tsh >= d_r) begin
          x_nxt = tsh - d_r;
          y_nxt = {y_r[62:0], 1'b1};
        end else begin
          x_nxt = tsh;
          y_nxt = {y_r[62:0], 1'b0};
        end
        z_nxt = {z_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sqrt_r <= sqrt_nxt;
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    d_r    <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = y_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("unit not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("start while busy");

endmodule

`default_nettype wire

FILE: rtl/path_follow_lookahead_steer_unit.sv
// Top level of the lookahead steering unit: path store, sequencer and result
// registers. Depends on plsu_pkg and plsu_divsqrt.
//
// A load request is taken in S_IDLE, never raises busy and gives no result. A
// step request on a non-empty path runs the shared divide/square-root unit for
// the end-of-path check, for each segment visited in the nearest-point walk and
// in the lookahead walk, and for the velocity; every square root runs with its
// squaring states S_SQX and S_SQY, and every fraction and quotient also runs in
// that single unit. busy stays high throughout. Each step gives one result as a
// one-cycle out_valid strobe that the receiver must take at once; there is no
// back-pressure.
`default_nettype none

module path_follow_lookahead_steer_unit #(
  parameter int MAX_POINTS = plsu_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = plsu_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_op,
  input  wire logic               in_first_point,
  input  wire logic signed [31:0] in_x_coord,
  input  wire logic signed [31:0] in_y_coord,
  input  wire logic [23:0]        in_time_step,
  output logic                    out_valid,
  output logic signed [31:0]      out_vel_x,
  output logic signed [31:0]      out_vel_y,
  output logic                    out_moving,
  output logic [5:0]              out_segment_at,
  input  wire logic               cfg_we,
  input  wire logic               cfg_idx,
  input  wire logic [23:0]        cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  plsu_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic                sq_only_r, sq_only_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic signed [31:0]  rx_r, rx_nxt, ry_r, ry_nxt;
  logic [AW-1:0]       rseg_r, rseg_nxt;
  logic [23:0]         speed_r, speed_nxt, la_r, la_nxt;
  logic signed [31:0]  qx_r, qx_nxt, qy_r, qy_nxt;
  logic [23:0]         dt_r, dt_nxt;
  logic [47:0]         travel_r, travel_nxt;
  logic signed [31:0]  cx_r, cx_nxt, cy_r, cy_nxt, nx_r, nx_nxt, ny_r, ny_nxt;
  logic signed [31:0]  ex_r, ex_nxt, ey_r, ey_nxt, mx_r, mx_nxt, my_r, my_nxt;
  logic signed [31:0]  ox_r, ox_nxt, oy_r, oy_nxt, bx_r, bx_nxt, by_r, by_nxt;
  logic signed [31:0]  sx_r, sx_nxt, sy_r, sy_nxt, apx_r, apx_nxt, apy_r, apy_nxt;
  logic [AW-1:0]       seg_r, seg_nxt, bseg_r, bseg_nxt;
  logic [32:0]         dist_r, dist_nxt;
  logic [31:0]         sl_r, sl_nxt, len_r, len_nxt;
  logic                found_r, found_nxt;
  logic [63:0]         best_r, best_nxt, acc_r, acc_nxt, den_r, den_nxt;
  logic signed [63:0]  num_r, num_nxt;
  logic [63:0]         fn_r, fn_nxt, fd_r, fd_nxt;
  logic [30:0]         t_r, t_nxt;
  logic signed [31:0]  vx_r, vx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic signed [31:0]  out_vx_r, out_vx_nxt, out_vy_r, out_vy_nxt;
  logic                out_mov_r, out_mov_nxt;
  logic [5:0]          out_seg_r, out_seg_nxt;

  logic [63:0]         mem [MAX_POINTS];
  logic [63:0]         rdata_r;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [63:0]         mem_wdata;

  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod;
  logic signed [63:0]  mf_off;
  logic signed [31:0]  mf_base;
  logic                mf_neg;
  logic signed [31:0]  mf_out;
  logic signed [63:0]  q_signed;
  logic signed [31:0]  q_clamped;

  logic [CW-1:0]       seg_p1, cnt_m1;
  logic [33:0]         ds;
  logic [AW+5:0]       rseg_w;
  logic [23:0]         la_left;

  plsu_pkg::dsu_req_t  dreq;
  plsu_pkg::dsu_rsp_t  drsp;
  logic [63:0]         d_a, d_n, d_d;

  plsu_divsqrt u_dsu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .a_in  (d_a),
    .n_in  (d_n),
    .d_in  (d_d),
    .rsp   (drsp)
  );

  assign seg_p1  = CW'(seg_r) + CW'(1);
  assign cnt_m1  = count_r - CW'(1);
  assign ds      = {1'b0, dist_r} + {2'b0, len_r};
  assign rseg_w  = {6'b0, rseg_r};
  assign la_left = la_r - dist_r[23:0];
  assign prod    = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      plsu_pkg::S_E_RD: begin
        mul_a = $signed({8'b0, speed_r});
        mul_b = $signed({8'b0, dt_r});
      end
      plsu_pkg::S_SQX: begin
        mul_a = sx_r;
        mul_b = sx_r;
      end
      plsu_pkg::S_SQY: begin
        mul_a = sy_r;
        mul_b = sy_r;
      end
      plsu_pkg::S_N_NUM1: begin
        mul_a = apx_r;
        mul_b = sx_r;
      end
      plsu_pkg::S_N_NUM2: begin
        mul_a = apy_r;
        mul_b = sy_r;
      end
      plsu_pkg::S_MF_X: begin
        mul_a = plsu_pkg::absv(sx_r);
        mul_b = $signed({1'b0, t_r});
      end
      plsu_pkg::S_MF_Y: begin
        mul_a = plsu_pkg::absv(sy_r);
        mul_b = $signed({1'b0, t_r});
      end
      plsu_pkg::S_VX_MUL: begin
        mul_a = plsu_pkg::absv(sx_r);
        mul_b = $signed({8'b0, speed_r});
      end
      plsu_pkg::S_VY_MUL: begin
        mul_a = plsu_pkg::absv(sy_r);
        mul_b = $signed({8'b0, speed_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    mf_neg  = (state_r == plsu_pkg::S_MF_X) ? sx_r[31] : sy_r[31];
    mf_base = (state_r == plsu_pkg::S_MF_X) ? cx_r : cy_r;
    mf_off  = prod >>> 30;
    if (mf_neg) begin
      mf_off = -mf_off;
    end
    mf_out  = plsu_pkg::clamp32({{32{mf_base[31]}}, mf_base} + mf_off);
    q_signed = $signed(drsp.res);
    if ((state_r == plsu_pkg::S_VX_WAIT) ? sx_r[31] : sy_r[31]) begin
      q_signed = -q_signed;
    end
    q_clamped = plsu_pkg::clamp32(q_signed);
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    sq_only_nxt   = sq_only_r;
    count_nxt     = count_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    rseg_nxt      = rseg_r;
    speed_nxt     = speed_r;
    la_nxt        = la_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    dt_nxt        = dt_r;
    travel_nxt    = travel_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    apx_nxt       = apx_r;
    apy_nxt       = apy_r;
    seg_nxt       = seg_r;
    bseg_nxt      = bseg_r;
    dist_nxt      = dist_r;
    sl_nxt        = sl_r;
    len_nxt       = len_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    acc_nxt       = acc_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    fn_nxt        = fn_r;
    fd_nxt        = fd_r;
    t_nxt         = t_r;
    vx_nxt        = vx_r;
    out_valid_nxt = 1'b0;
    out_vx_nxt    = out_vx_r;
    out_vy_nxt    = out_vy_r;
    out_mov_nxt   = out_mov_r;
    out_seg_nxt   = out_seg_r;
    rd_addr       = seg_p1[AW-1:0];
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = {in_x_coord, in_y_coord};
    dreq          = '0;
    d_a           = '0;
    d_n           = '0;
    d_d           = {32'b0, len_r};

    if (cfg_we) begin
      unique case (cfg_idx)
        plsu_pkg::REG_SPEED:     speed_nxt = cfg_wdata;
        plsu_pkg::REG_LOOKAHEAD: la_nxt    = cfg_wdata;
        default:                 speed_nxt = speed_r;
      endcase
    end

    unique case (state_r)
      plsu_pkg::S_IDLE: begin
        if (start) begin
          if (in_op == plsu_pkg::OP_LOAD) begin
            if (in_first_point || count_r == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              count_nxt = CW'(1);
              rx_nxt    = in_x_coord;
              ry_nxt    = in_y_coord;
              rseg_nxt  = '0;
            end else if (count_r < CW'(MAX_POINTS)) begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else begin
            qx_nxt = in_x_coord;
            qy_nxt = in_y_coord;
            dt_nxt = in_time_step;
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_vx_nxt    = '0;
              out_vy_nxt    = '0;
              out_mov_nxt   = 1'b0;
              out_seg_nxt   = rseg_w[5:0];
            end else begin
              state_nxt = plsu_pkg::S_E_RD;
            end
          end
        end
      end
      plsu_pkg::S_E_RD: begin
        rd_addr    = cnt_m1[AW-1:0];
        travel_nxt = prod[47:0] >> FRAC_BITS;
        state_nxt  = plsu_pkg::S_E_DAT;
      end
      plsu_pkg::S_E_DAT: begin
        sx_nxt      = plsu_pkg::sdiff(qx_r, rdata_r[63:32]);
        sy_nxt      = plsu_pkg::sdiff(qy_r, rdata_r[31:0]);
        ret_nxt     = plsu_pkg::S_E_CMP;
        sq_only_nxt = 1'b0;
        state_nxt   = plsu_pkg::S_SQX;
      end
      plsu_pkg::S_E_CMP: begin
        if ({16'b0, len_r} >= travel_r) begin
          cx_nxt    = rx_r;
          cy_nxt    = ry_r;
          seg_nxt   = rseg_r;
          dist_nxt  = '0;
          found_nxt = 1'b0;
          bx_nxt    = rx_r;
          by_nxt    = ry_r;
          bseg_nxt  = rseg_r;
          state_nxt = plsu_pkg::S_W1_CHK;
        end else begin
          out_valid_nxt = 1'b1;
          out_vx_nxt    = '0;
          out_vy_nxt    = '0;
          out_mov_nxt   = 1'b0;
          out_seg_nxt   = rseg_w[5:0];
          state_nxt     = plsu_pkg::S_IDLE;
        end
      end
      plsu_pkg::S_W1_CHK: begin
        if (seg_p1 < count_r && dist_r < {9'b0, la_r}) begin
          state_nxt = plsu_pkg::S_W1_RD;
        end else begin
          rx_nxt    = bx_r;
          ry_nxt    = by_r;
          rseg_nxt  = bseg_r;
          cx_nxt    = bx_r;
          cy_nxt    = by_r;
          seg_nxt   = bseg_r;
          dist_nxt  = '0;
          state_nxt = plsu_pkg::S_W2_CHK;
        end
      end
      plsu_pkg::S_W1_RD: begin
        nx_nxt      = rdata_r[63:32];
        ny_nxt      = rdata_r[31:0];
        sx_nxt      = plsu_pkg::sdiff(rdata_r[63:32], cx_r);
        sy_nxt      = plsu_pkg::sdiff(rdata_r[31:0], cy_r);
        ret_nxt     = plsu_pkg::S_W1_SL;
        sq_only_nxt = 1'b0;
        state_nxt   = plsu_pkg::S_SQX;
      end
      plsu_pkg::S_W1_SL: begin
        sl_nxt = len_r;
        if (ds <= {10'b0, la_r}) begin
          ex_nxt    = nx_r;
          ey_nxt    = ny_r;
          state_nxt = plsu_pkg::S_W1_NS;
        end else begin
          fn_nxt    = {40'b0, la_left};
          fd_nxt    = {32'b0, len_r};
          ret_nxt   = plsu_pkg::S_W1_MF;
          state_nxt = plsu_pkg::S_FR_GO;
        end
      end
      plsu_pkg::S_W1_MF: begin
        ret_nxt   = plsu_pkg::S_W1_EXD;
        state_nxt = plsu_pkg::S_MF_X;
      end
      plsu_pkg::S_W1_EXD: begin
        ex_nxt    = ox_r;
        ey_nxt    = oy_r;
        state_nxt = plsu_pkg::S_W1_NS;
      end
      plsu_pkg::S_W1_NS: begin
        sx_nxt      = plsu_pkg::sdiff(ex_r, cx_r);
        sy_nxt      = plsu_pkg::sdiff(ey_r, cy_r);
        apx_nxt     = plsu_pkg::sdiff(qx_r, cx_r);
        apy_nxt     = plsu_pkg::sdiff(qy_r, cy_r);
        ret_nxt     = plsu_pkg::S_N_NUM1;
        sq_only_nxt = 1'b1;
        state_nxt   = plsu_pkg::S_SQX;
      end
      plsu_pkg::S_N_NUM1: begin
        den_nxt   = acc_r;
        num_nxt   = prod;
        state_nxt = plsu_pkg::S_N_NUM2;
      end
      plsu_pkg::S_N_NUM2: begin
        num_nxt   = num_r + prod;
        state_nxt = plsu_pkg::S_N_DEC;
      end
      plsu_pkg::S_N_DEC: begin
        if (den_r == '0 || num_r <= 64'sd0) begin
          mx_nxt    = cx_r;
          my_nxt    = cy_r;
          state_nxt = plsu_pkg::S_W1_D2;
        end else if ($unsigned(num_r) >= den_r) begin
          mx_nxt    = ex_r;
          my_nxt    = ey_r;
          state_nxt = plsu_pkg::S_W1_D2;
        end else begin
          fn_nxt    = $unsigned(num_r);
          fd_nxt    = den_r;
          ret_nxt   = plsu_pkg::S_N_MF;
          state_nxt = plsu_pkg::S_FR_GO;
        end
      end
      plsu_pkg::S_N_MF: begin
        ret_nxt   = plsu_pkg::S_N_MFD;
        state_nxt = plsu_pkg::S_MF_X;
      end
      plsu_pkg::S_N_MFD: begin
        mx_nxt    = ox_r;
        my_nxt    = oy_r;
        state_nxt = plsu_pkg::S_W1_D2;
      end
      plsu_pkg::S_W1_D2: begin
        sx_nxt      = plsu_pkg::sdiff(qx_r, mx_r);
        sy_nxt      = plsu_pkg::sdiff(qy_r, my_r);
        ret_nxt     = plsu_pkg::S_W1_UPD;
        sq_only_nxt = 1'b1;
        state_nxt   = plsu_pkg::S_SQX;
      end
      plsu_pkg::S_W1_UPD: begin
        if (!found_r || acc_r <= best_r) begin
          found_nxt = 1'b1;
          best_nxt  = acc_r;
          bx_nxt    = mx_r;
          by_nxt    = my_r;
          bseg_nxt  = seg_r;
        end
        cx_nxt    = nx_r;
        cy_nxt    = ny_r;
        dist_nxt  = dist_r + {1'b0, sl_r};
        seg_nxt   = seg_r + AW'(1);
        state_nxt = plsu_pkg::S_W1_CHK;
      end
      plsu_pkg::S_W2_CHK: begin
        if (seg_p1 < count_r && dist_r < {9'b0, la_r}) begin
          state_nxt = plsu_pkg::S_W2_RD;
        end else begin
          state_nxt = plsu_pkg::S_V_DIR;
        end
      end
      plsu_pkg::S_W2_RD: begin
        nx_nxt      = rdata_r[63:32];
        ny_nxt      = rdata_r[31:0];
        sx_nxt      = plsu_pkg::sdiff(rdata_r[63:32], cx_r);
        sy_nxt      = plsu_pkg::sdiff(rdata_r[31:0], cy_r);
        ret_nxt     = plsu_pkg::S_W2_SL;
        sq_only_nxt = 1'b0;
        state_nxt   = plsu_pkg::S_SQX;
      end
      plsu_pkg::S_W2_SL: begin
        if (ds < {10'b0, la_r}) begin
          cx_nxt    = nx_r;
          cy_nxt    = ny_r;
          seg_nxt   = seg_r + AW'(1);
          dist_nxt  = ds[32:0];
          state_nxt = plsu_pkg::S_W2_CHK;
        end else begin
          fn_nxt    = {40'b0, la_left};
          fd_nxt    = {32'b0, len_r};
          ret_nxt   = plsu_pkg::S_W2_MF;
          state_nxt = plsu_pkg::S_FR_GO;
        end
      end
      plsu_pkg::S_W2_MF: begin
        ret_nxt   = plsu_pkg::S_W2_END;
        state_nxt = plsu_pkg::S_MF_X;
      end
      plsu_pkg::S_W2_END: begin
        cx_nxt    = ox_r;
        cy_nxt    = oy_r;
        state_nxt = plsu_pkg::S_V_DIR;
      end
      plsu_pkg::S_V_DIR: begin
        sx_nxt      = plsu_pkg::sdiff(cx_r, qx_r);
        sy_nxt      = plsu_pkg::sdiff(cy_r, qy_r);
        ret_nxt     = plsu_pkg::S_V_LEN;
        sq_only_nxt = 1'b0;
        state_nxt   = plsu_pkg::S_SQX;
      end
      plsu_pkg::S_V_LEN: begin
        if (len_r == '0) begin
          out_valid_nxt = 1'b1;
          out_vx_nxt    = '0;
          out_vy_nxt    = '0;
          out_mov_nxt   = 1'b0;
          out_seg_nxt   = rseg_w[5:0];
          state_nxt     = plsu_pkg::S_IDLE;
        end else begin
          state_nxt = plsu_pkg::S_VX_MUL;
        end
      end
      plsu_pkg::S_VX_MUL: begin
        num_nxt   = prod;
        state_nxt = plsu_pkg::S_VX_GO;
      end
      plsu_pkg::S_VX_GO: begin
        dreq.start = 1'b1;
        dreq.steps = plsu_pkg::QUOT_STEPS;
        d_n        = $unsigned(num_r);
        state_nxt  = plsu_pkg::S_VX_WAIT;
      end
      plsu_pkg::S_VX_WAIT: begin
        if (drsp.done) begin
          vx_nxt    = q_clamped;
          state_nxt = plsu_pkg::S_VY_MUL;
        end
      end
      plsu_pkg::S_VY_MUL: begin
        num_nxt   = prod;
        state_nxt = plsu_pkg::S_VY_GO;
      end
      plsu_pkg::S_VY_GO: begin
        dreq.start = 1'b1;
        dreq.steps = plsu_pkg::QUOT_STEPS;
        d_n        = $unsigned(num_r);
        state_nxt  = plsu_pkg::S_VY_WAIT;
      end
      plsu_pkg::S_VY_WAIT: begin
        if (drsp.done) begin
          out_valid_nxt = 1'b1;
          out_vx_nxt    = vx_r;
          out_vy_nxt    = q_clamped;
          out_mov_nxt   = (vx_r != '0) || (q_clamped != '0);
          out_seg_nxt   = rseg_w[5:0];
          state_nxt     = plsu_pkg::S_IDLE;
        end
      end
      plsu_pkg::S_SQX: begin
        acc_nxt   = $unsigned(prod);
        state_nxt = plsu_pkg::S_SQY;
      end
      plsu_pkg::S_SQY: begin
        acc_nxt   = acc_r + $unsigned(prod);
        state_nxt = sq_only_r ? ret_r : plsu_pkg::S_RT_GO;
      end
      plsu_pkg::S_RT_GO: begin
        dreq.start = 1'b1;
        dreq.sqrt  = 1'b1;
        dreq.steps = plsu_pkg::SQRT_STEPS;
        d_a        = acc_r;
        state_nxt  = plsu_pkg::S_RT_WAIT;
      end
      plsu_pkg::S_RT_WAIT: begin
        if (drsp.done) begin
          len_nxt   = drsp.res[31:0];
          state_nxt = ret_r;
        end
      end
      plsu_pkg::S_FR_GO: begin
        if (fd_r == '0 || fn_r >= fd_r) begin
          t_nxt     = plsu_pkg::ONE30;
          state_nxt = ret_r;
        end else begin
          dreq.start = 1'b1;
          dreq.steps = plsu_pkg::FRAC_STEPS;
          d_a        = fn_r;
          d_d        = fd_r;
          state_nxt  = plsu_pkg::S_FR_WAIT;
        end
      end
      plsu_pkg::S_FR_WAIT: begin
        if (drsp.done) begin
          t_nxt     = drsp.res[30:0];
          state_nxt = ret_r;
        end
      end
      plsu_pkg::S_MF_X: begin
        ox_nxt    = mf_out;
        state_nxt = plsu_pkg::S_MF_Y;
      end
      plsu_pkg::S_MF_Y: begin
        oy_nxt    = mf_out;
        state_nxt = ret_r;
      end
      default: begin
        state_nxt = plsu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plsu_pkg::S_IDLE;
      ret_r       <= plsu_pkg::S_IDLE;
      count_r     <= '0;
      rx_r        <= '0;
      ry_r        <= '0;
      rseg_r      <= '0;
      speed_r     <= plsu_pkg::SPEED_RST;
      la_r        <= plsu_pkg::LOOKAHEAD_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      count_r     <= count_nxt;
      rx_r        <= rx_nxt;
      ry_r        <= ry_nxt;
      rseg_r      <= rseg_nxt;
      speed_r     <= speed_nxt;
      la_r        <= la_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sq_only_r <= sq_only_nxt;
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    dt_r      <= dt_nxt;
    travel_r  <= travel_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    nx_r      <= nx_nxt;
    ny_r      <= ny_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    bx_r      <= bx_nxt;
    by_r      <= by_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    apx_r     <= apx_nxt;
    apy_r     <= apy_nxt;
    seg_r     <= seg_nxt;
    bseg_r    <= bseg_nxt;
    dist_r    <= dist_nxt;
    sl_r      <= sl_nxt;
    len_r     <= len_nxt;
    found_r   <= found_nxt;
    best_r    <= best_nxt;
    acc_r     <= acc_nxt;
    den_r     <= den_nxt;
    num_r     <= num_nxt;
    fn_r      <= fn_nxt;
    fd_r      <= fd_nxt;
    t_r       <= t_nxt;
    vx_r      <= vx_nxt;
    out_vx_r  <= out_vx_nxt;
    out_vy_r  <= out_vy_nxt;
    out_mov_r <= out_mov_nxt;
    out_seg_r <= out_seg_nxt;
  end

  assign busy           = (state_r != plsu_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_vel_x      = out_vx_r;
  assign out_vel_y      = out_vy_r;
  assign out_moving     = out_mov_r;
  assign out_segment_at = out_seg_r;

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == plsu_pkg::S_IDLE) else $error("result outside idle");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS)) else $error("path count overflow");
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == plsu_pkg::OP_LOAD |=> !out_valid_r)
    else $error("result after load request");
  a_ref_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 || CW'(rseg_r) < count_r) else $error("reference segment past path");

endmodule

`default_nettype wire

FILE: tb/sv/path_follow_lookahead_steer_unit_test.sv
// Testbench for path_follow_lookahead_steer_unit: loads paths, sends steering
// requests and checks each velocity result against a built-in predictor.
// Depends on plsu_pkg and the unit's RTL.
`default_nettype none

module path_follow_lookahead_steer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 64;
  localparam longint DLIM = 64'd1073741823;
  localparam longint unsigned ONE = 64'd1 << 30;
  localparam int UNIT = 65536;

  typedef struct {
    int       vel_x;
    int       vel_y;
    bit       moving;
    bit [5:0] seg;
  } steer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_op = plsu_pkg::OP_LOAD;
  logic               in_first_point = 1'b0;
  logic signed [31:0] in_x_coord = '0;
  logic signed [31:0] in_y_coord = '0;
  logic [23:0]        in_time_step = '0;
  logic               out_valid;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic               out_moving;
  logic [5:0]         out_segment_at;
  logic               cfg_we = 1'b0;
  logic               cfg_idx = plsu_pkg::REG_SPEED;
  logic [23:0]        cfg_wdata = '0;

  path_follow_lookahead_steer_unit i_dut (.*);

  always #1 clk = ~clk;

  int path_x[NPTS];
  int path_y[NPTS];
  int path_len;
  int ref_x, ref_y;
  int ref_seg;
  longint unsigned spd, look;

  steer_t steer_expected[$];
  int gap_pct;
  int errors;
  int n_loads, n_steps, n_checked, n_moving;

  function automatic longint sat_diff(int a, int b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d > DLIM) return DLIM;
    if (d < -DLIM) return -DLIM;
    return d;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned ratio30(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    if (d == 0 || n >= d) return ONE;
    q = 0;
    r = n;
    for (int i = 0; i < 30; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint scale30(longint v, longint unsigned t);
    longint unsigned m, p;
    m = (v < 0) ? longint'(-v) : v;
    p = (m * t) >> 30;
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned dist2(longint dx, longint dy);
    return longint'(dx * dx + dy * dy);
  endfunction

  function automatic void closest_on_seg(int qx, int qy, int ax, int ay, int bx, int by,
                                         output int ox, output int oy);
    longint abx, aby, apx, apy, den, num;
    longint unsigned t;
    abx = sat_diff(bx, ax);
    aby = sat_diff(by, ay);
    apx = sat_diff(qx, ax);
    apy = sat_diff(qy, ay);
    den = abx * abx + aby * aby;
    num = apx * abx + apy * aby;
    ox = ax;
    oy = ay;
    if (den == 0 || num <= 0) return;
    if (num >= den) begin
      ox = bx;
      oy = by;
      return;
    end
    t = ratio30(num, den);
    ox = sat32(longint'(ax) + scale30(abx, t));
    oy = sat32(longint'(ay) + scale30(aby, t));
  endfunction

  function automatic steer_t predict_steer(int qx, int qy, bit [23:0] dt);
    steer_t res;
    longint unsigned travel, walked, sl, t, best, d2, len;
    longint dx, dy, sx, sy, vx, vy;
    int cx, cy, nx, ny, ex, ey, mx, my, bx, by, seg, bseg;
    bit found;
    vx = 0;
    vy = 0;
    travel = (spd * longint'(dt)) >> 16;
    if (path_len > 0) begin
      dx = sat_diff(qx, path_x[path_len - 1]);
      dy = sat_diff(qy, path_y[path_len - 1]);
    end
    if (path_len > 0 && floor_sqrt(dist2(dx, dy)) >= travel) begin
      found = 0;
      best = 0;
      bx = ref_x;
      by = ref_y;
      bseg = ref_seg;
      cx = ref_x;
      cy = ref_y;
      seg = ref_seg;
      walked = 0;
      while (seg + 1 < path_len && walked < look) begin
        nx = path_x[seg + 1];
        ny = path_y[seg + 1];
        sx = sat_diff(nx, cx);
        sy = sat_diff(ny, cy);
        sl = floor_sqrt(dist2(sx, sy));
        if (walked + sl <= look) begin
          ex = nx;
          ey = ny;
        end else begin
          t = ratio30(look - walked, sl);
          ex = sat32(longint'(cx) + scale30(sx, t));
          ey = sat32(longint'(cy) + scale30(sy, t));
        end
        closest_on_seg(qx, qy, cx, cy, ex, ey, mx, my);
        d2 = dist2(sat_diff(qx, mx), sat_diff(qy, my));
        if (!found || d2 <= best) begin
          found = 1;
          best = d2;
          bx = mx;
          by = my;
          bseg = seg;
        end
        cx = nx;
        cy = ny;
        walked += sl;
        seg++;
      end
      ref_x = bx;
      ref_y = by;
      ref_seg = bseg;

      cx = ref_x;
      cy = ref_y;
      seg = ref_seg;
      walked = 0;
      while (seg + 1 < path_len && walked < look) begin
        nx = path_x[seg + 1];
        ny = path_y[seg + 1];
        sx = sat_diff(nx, cx);
        sy = sat_diff(ny, cy);
        sl = floor_sqrt(dist2(sx, sy));
        if (walked + sl < look) begin
          cx = nx;
          cy = ny;
          seg++;
          walked += sl;
        end else begin
          t = ratio30(look - walked, sl);
          cx = sat32(longint'(cx) + scale30(sx, t));
          cy = sat32(longint'(cy) + scale30(sy, t));
          break;
        end
      end
      dx = sat_diff(cx, qx);
      dy = sat_diff(cy, qy);
      len = floor_sqrt(dist2(dx, dy));
      if (len != 0) begin
        vx = dx * longint'(spd) / longint'(len);
        vy = dy * longint'(spd) / longint'(len);
      end
    end
    res.vel_x = sat32(vx);
    res.vel_y = sat32(vy);
    res.moving = (vx != 0 || vy != 0);
    res.seg = ref_seg[5:0];
    return res;
  endfunction

  function automatic void store_point(bit fp, int x, int y);
    if (fp || path_len == 0) begin
      path_x[0] = x;
      path_y[0] = y;
      path_len = 1;
      ref_x = x;
      ref_y = y;
      ref_seg = 0;
    end else if (path_len < NPTS) begin
      path_x[path_len] = x;
      path_y[path_len] = y;
      path_len++;
    end
  endfunction

  // call at a falling edge; returns at a falling edge with start possibly still high
  task automatic send_request(bit op, bit fp, int x, int y, bit [23:0] dt);
    in_op <= op;
    in_first_point <= fp;
    in_x_coord <= x;
    in_y_coord <= y;
    in_time_step <= dt;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == plsu_pkg::OP_LOAD) begin
      store_point(fp, x, y);
      n_loads++;
    end else begin
      steer_expected.push_back(predict_steer(x, y, dt));
      n_steps++;
    end
    @(negedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (steer_expected.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == plsu_pkg::REG_SPEED) spd = val;
    else look = val;
  endtask

  always @(posedge clk) begin
    steer_t e;
    if (rst_n && out_valid) begin
      if (steer_expected.size() == 0) begin
        $error("unexpected result vel_x=%0d vel_y=%0d", out_vel_x, out_vel_y);
        errors++;
      end else begin
        e = steer_expected.pop_front();
        n_checked++;
        if (e.moving) n_moving++;
        if (out_vel_x !== e.vel_x) begin
          $error("vel_x expected %0d actual %0d", e.vel_x, out_vel_x);
          errors++;
        end
        if (out_vel_y !== e.vel_y) begin
          $error("vel_y expected %0d actual %0d", e.vel_y, out_vel_y);
          errors++;
        end
        if (out_moving !== e.moving) begin
          $error("moving expected %0d actual %0d", e.moving, out_moving);
          errors++;
        end
        if (out_segment_at !== e.seg) begin
          $error("segment_at expected %0d actual %0d", e.seg, out_segment_at);
          errors++;
        end
      end
    end
  end

  function automatic int rand_coord(int base);
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return base + int'($urandom_range(0, 8 * UNIT)) - 4 * UNIT;
    endcase
  endfunction

  function automatic bit [23:0] rand_dt();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 24'hff_ffff);
      1: return 0;
      default: return $urandom_range(0, UNIT / 2);
    endcase
  endfunction

  task automatic test_directed();
    send_request(plsu_pkg::OP_STEP, 0, 0, 0, 24'd100);
    send_request(plsu_pkg::OP_LOAD, 0, 5 * UNIT, 5 * UNIT, 0);
    send_request(plsu_pkg::OP_STEP, 0, 5 * UNIT, 5 * UNIT, 0);
    send_request(plsu_pkg::OP_STEP, 0, 7 * UNIT, 5 * UNIT, 0);
    send_request(plsu_pkg::OP_LOAD, 1, 0, 0, 0);
    send_request(plsu_pkg::OP_LOAD, 0, 2 * UNIT, 0, 0);
    send_request(plsu_pkg::OP_LOAD, 0, 2 * UNIT, 2 * UNIT, 0);
    send_request(plsu_pkg::OP_STEP, 0, UNIT / 4, UNIT / 2, 24'd1000);
    send_request(plsu_pkg::OP_STEP, 0, 2 * UNIT, 2 * UNIT, 24'd10);
    send_request(plsu_pkg::OP_STEP, 0, 2 * UNIT, UNIT, 24'hff_ffff);
    send_request(plsu_pkg::OP_STEP, 0, 32'h7fff_ffff, 32'h8000_0000, 24'd0);
    send_request(plsu_pkg::OP_STEP, 0, 32'h8000_0000, 32'h7fff_ffff, 24'd1);
    send_request(plsu_pkg::OP_LOAD, 1, 32'h8000_0000, 32'h8000_0000, 24'hff_ffff);
    send_request(plsu_pkg::OP_LOAD, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_request(plsu_pkg::OP_STEP, 0, 0, 0, 0);
    send_request(plsu_pkg::OP_STEP, 1, 32'h7fff_ffff, 32'h8000_0000, 24'hff_ffff);
    send_request(plsu_pkg::OP_STEP, 0, 32'h7fff_fff0, 32'h7fff_fff0, 24'd0);
  endtask

  task automatic test_full_path();
    send_request(plsu_pkg::OP_LOAD, 1, 0, 0, 0);
    for (int i = 1; i < NPTS + 3; i++)
      send_request(plsu_pkg::OP_LOAD, 0, i * UNIT / 4, (i % 2) * UNIT / 8, 0);
    for (int i = 0; i < 4; i++)
      send_request(plsu_pkg::OP_STEP, 0, i * 4 * UNIT, 0, 24'd16);
    send_request(plsu_pkg::OP_STEP, 0, 16 * UNIT, 0, 24'd0);
  endtask

  task automatic test_random(int n_items);
    int sent, npts, k, x, y;
    sent = 0;
    while (sent < n_items) begin
      npts = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
      x = rand_coord(0);
      y = rand_coord(0);
      for (int i = 0; i < npts; i++) begin
        send_request(plsu_pkg::OP_LOAD, (i == 0) ? ($urandom_range(0, 7) != 0) : 1'b0,
                     x, y, $urandom_range(0, 24'hff_ffff));
        x = rand_coord(x);
        y = rand_coord(y);
        sent++;
      end
      repeat ($urandom_range(2, 8)) begin
        k = $urandom_range(0, path_len - 1);
        case ($urandom_range(0, 9))
          0: send_request(plsu_pkg::OP_STEP, $urandom_range(0, 1), path_x[path_len - 1],
                          path_y[path_len - 1], rand_dt());
          1: send_request(plsu_pkg::OP_STEP, $urandom_range(0, 1), $urandom, $urandom,
                          rand_dt());
          default: send_request(plsu_pkg::OP_STEP, 0, rand_coord(path_x[k]),
                                rand_coord(path_y[k]), rand_dt());
        endcase
        sent++;
      end
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  task automatic test_config_sweep();
    gap_pct = 33;
    write_reg(plsu_pkg::REG_SPEED, UNIT);
    write_reg(plsu_pkg::REG_LOOKAHEAD, 3 * UNIT);
    test_random(250);
    gap_pct = 45;
    write_reg(plsu_pkg::REG_SPEED, 24'hff_ffff);
    write_reg(plsu_pkg::REG_LOOKAHEAD, 24'd0);
    test_random(200);
    gap_pct = 0;
    write_reg(plsu_pkg::REG_SPEED, 24'd0);
    write_reg(plsu_pkg::REG_LOOKAHEAD, 24'hff_ffff);
    test_random(120);
    write_reg(plsu_pkg::REG_SPEED, $urandom_range(1, 24'hff_ffff));
    write_reg(plsu_pkg::REG_LOOKAHEAD, $urandom_range(UNIT / 4, 8 * UNIT));
    test_random(250);
  endtask

  initial begin
    path_len = 0;
    ref_x = 0;
    ref_y = 0;
    ref_seg = 0;
    spd = plsu_pkg::SPEED_RST;
    look = plsu_pkg::LOOKAHEAD_RST;
    gap_pct = 0;
    errors = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_full_path();
    test_config_sweep();
    drain_results();
    repeat (300) @(negedge clk);
    $display("covered %0d path loads and %0d steering requests, %0d results checked",
             n_loads, n_steps, n_checked);
    $display("%0d results moving, speed and lookahead swept to both extremes", n_moving);
    if (errors == 0 && steer_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
